>>> rtl/itag_pkg.sv
// Shared types, constants and control structs for the im2col tap address generator.
package itag_pkg;

    // Window and image limits
    localparam int MAX_KERNEL = 8;
    localparam int MAX_DIM    = 1024;

    // Field widths
    localparam int KERN_W  = 4;
    localparam int STR_W   = 4;
    localparam int PAD_W   = 3;
    localparam int DIM_W   = 11;
    localparam int BATCH_W = 8;
    localparam int COORD_W = 10;
    localparam int SLOT_W  = 6;
    localparam int TAP_W   = $clog2(MAX_KERNEL);
    // Signed base coordinate: coord * stride - pad, with headroom for the tap offset
    localparam int BASE_W  = COORD_W + STR_W + 2;

    // APB register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_KERNEL_HEIGHT = 3'd0,
        REG_KERNEL_WIDTH  = 3'd1,
        REG_STRIDE_Y      = 3'd2,
        REG_STRIDE_X      = 3'd3,
        REG_PAD_TOP       = 3'd4,
        REG_PAD_LEFT      = 3'd5,
        REG_IN_HEIGHT     = 3'd6,
        REG_IN_WIDTH      = 3'd7
    } t_reg_idx;

    // Item modes
    localparam logic KIND_GATHER  = 1'b0;
    localparam logic KIND_SCATTER = 1'b1;

    typedef struct packed {
        logic [KERN_W-1:0] kernel_height;
        logic [KERN_W-1:0] kernel_width;
        logic [STR_W-1:0]  stride_y;
        logic [STR_W-1:0]  stride_x;
        logic [PAD_W-1:0]  pad_top;
        logic [PAD_W-1:0]  pad_left;
        logic [DIM_W-1:0]  in_height;
        logic [DIM_W-1:0]  in_width;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_MASK,
        ST_WALK
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic calc_base;
        logic calc_mask;
        logic step;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic kernel_empty;
        logic tap_final;
        logic tap_emit;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/itag_if.sv
// Handshake interfaces for the position input channel and the tap record output channel.
interface itag_in_if import itag_pkg::*; ;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [BATCH_W-1:0] batch_index;
    logic [COORD_W-1:0] out_y;
    logic [COORD_W-1:0] out_x;

    modport source (output valid, kind, batch_index, out_y, out_x, input ready);
    modport sink   (input valid, kind, batch_index, out_y, out_x, output ready);
endinterface

interface itag_out_if import itag_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [BATCH_W-1:0] batch_out;
    logic [COORD_W-1:0] in_y;
    logic [COORD_W-1:0] in_x;
    logic [SLOT_W-1:0]  slot_index;
    logic               zero_fill;
    logic               last;

    modport source (output valid, batch_out, in_y, in_x, slot_index, zero_fill, last,
                    input ready);
    modport sink   (input valid, batch_out, in_y, in_x, slot_index, zero_fill, last,
                    output ready);
endinterface

>>> rtl/itag_cfg.sv
// APB configuration register file.
module itag_cfg import itag_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kernel_height <= KERN_W'(3);
            r_cfg.kernel_width  <= KERN_W'(3);
            r_cfg.stride_y      <= STR_W'(1);
            r_cfg.stride_x      <= STR_W'(1);
            r_cfg.pad_top       <= '0;
            r_cfg.pad_left      <= '0;
            r_cfg.in_height     <= DIM_W'(MAX_DIM);
            r_cfg.in_width      <= DIM_W'(MAX_DIM);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_KERNEL_HEIGHT: r_cfg.kernel_height <= pwdata[KERN_W-1:0];
                REG_KERNEL_WIDTH:  r_cfg.kernel_width  <= pwdata[KERN_W-1:0];
                REG_STRIDE_Y:      r_cfg.stride_y      <= pwdata[STR_W-1:0];
                REG_STRIDE_X:      r_cfg.stride_x      <= pwdata[STR_W-1:0];
                REG_PAD_TOP:       r_cfg.pad_top       <= pwdata[PAD_W-1:0];
                REG_PAD_LEFT:      r_cfg.pad_left      <= pwdata[PAD_W-1:0];
                REG_IN_HEIGHT:     r_cfg.in_height     <= pwdata[DIM_W-1:0];
                REG_IN_WIDTH:      r_cfg.in_width      <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            REG_KERNEL_HEIGHT: prdata = DATA_W'(r_cfg.kernel_height);
            REG_KERNEL_WIDTH:  prdata = DATA_W'(r_cfg.kernel_width);
            REG_STRIDE_Y:      prdata = DATA_W'(r_cfg.stride_y);
            REG_STRIDE_X:      prdata = DATA_W'(r_cfg.stride_x);
            REG_PAD_TOP:       prdata = DATA_W'(r_cfg.pad_top);
            REG_PAD_LEFT:      prdata = DATA_W'(r_cfg.pad_left);
            REG_IN_HEIGHT:     prdata = DATA_W'(r_cfg.in_height);
            REG_IN_WIDTH:      prdata = DATA_W'(r_cfg.in_width);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/itag_ctrl.sv
// Sequencing state machine: accept, base computation, padding masks, tap walk.
module itag_ctrl import itag_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_BASE;
                end
            end
            ST_BASE: begin
                o_cmd.calc_base = 1'b1;
                n_state         = ST_MASK;
            end
            ST_MASK: begin
                o_cmd.calc_mask = 1'b1;
                n_state         = i_sts.kernel_empty ? ST_IDLE : ST_WALK;
            end
            ST_WALK: begin
                // padded taps in scatter-add mode advance without a record
                if (!i_sts.tap_emit || i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    o_cmd.emit = i_sts.tap_emit;
                    if (i_sts.tap_final) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/itag_dp.sv
// Datapath: base coordinates, per-row and per-column padding masks, tap counters, output register.
module itag_dp import itag_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_cmd          i_cmd,
    output t_sts          o_sts,
    itag_in_if.sink       i_in,
    itag_out_if.source    o_out
);

    // Item registers
    logic                      r_kind;
    logic [BATCH_W-1:0]        r_batch;
    logic [COORD_W-1:0]        r_oy;
    logic [COORD_W-1:0]        r_ox;
    logic signed [BASE_W-1:0]  r_base_y;
    logic signed [BASE_W-1:0]  r_base_x;
    logic [MAX_KERNEL-1:0]     r_row_ok;
    logic [MAX_KERNEL-1:0]     r_col_ok;
    logic [TAP_W-1:0]          r_row;
    logic [TAP_W-1:0]          r_col;
    logic [SLOT_W-1:0]         r_slot;

    // Output register
    logic                      r_out_valid;
    logic [BATCH_W-1:0]        r_out_batch;
    logic [COORD_W-1:0]        r_out_y;
    logic [COORD_W-1:0]        r_out_x;
    logic [SLOT_W-1:0]         r_out_slot;
    logic                      r_out_zero;
    logic                      r_out_last;

    logic [KERN_W-1:0]         w_kh;
    logic [KERN_W-1:0]         w_kw;
    logic [DIM_W-1:0]          w_h;
    logic [DIM_W-1:0]          w_w;
    logic [MAX_KERNEL-1:0]     w_row_ok;
    logic [MAX_KERNEL-1:0]     w_col_ok;
    logic signed [BASE_W-1:0]  w_tap_y [MAX_KERNEL];
    logic signed [BASE_W-1:0]  w_tap_x [MAX_KERNEL];
    logic [COORD_W+STR_W-1:0]  w_prod_y;
    logic [COORD_W+STR_W-1:0]  w_prod_x;
    logic                      w_last_col;
    logic                      w_last_row;
    logic                      w_padded;
    logic [MAX_KERNEL-1:0]     w_cols_after;
    logic [MAX_KERNEL-1:0]     w_rows_after;
    logic                      w_more;
    logic                      w_rec_last;
    logic signed [BASE_W-1:0]  w_cur_y;
    logic signed [BASE_W-1:0]  w_cur_x;

    // Saturate kernel and image sizes
    assign w_kh = (i_cfg.kernel_height > KERN_W'(MAX_KERNEL)) ? KERN_W'(MAX_KERNEL)
                                                              : i_cfg.kernel_height;
    assign w_kw = (i_cfg.kernel_width > KERN_W'(MAX_KERNEL)) ? KERN_W'(MAX_KERNEL)
                                                             : i_cfg.kernel_width;
    assign w_h  = (i_cfg.in_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.in_height;
    assign w_w  = (i_cfg.in_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.in_width;

    assign w_prod_y = r_oy * i_cfg.stride_y;
    assign w_prod_x = r_ox * i_cfg.stride_x;

    // Per-row and per-column in-image masks, one comparator pair per kernel position
    always_comb begin
        for (int i = 0; i < MAX_KERNEL; i++) begin
            w_tap_y[i]  = r_base_y + BASE_W'(i);
            w_tap_x[i]  = r_base_x + BASE_W'(i);
            w_row_ok[i] = (KERN_W'(i) < w_kh) && !w_tap_y[i][BASE_W-1] &&
                          (w_tap_y[i] < $signed(BASE_W'(w_h)));
            w_col_ok[i] = (KERN_W'(i) < w_kw) && !w_tap_x[i][BASE_W-1] &&
                          (w_tap_x[i] < $signed(BASE_W'(w_w)));
        end
    end

    // Current tap
    assign w_last_col = ({1'b0, r_col} == KERN_W'(w_kw - KERN_W'(1)));
    assign w_last_row = ({1'b0, r_row} == KERN_W'(w_kh - KERN_W'(1)));
    assign w_padded   = !(r_row_ok[r_row] && r_col_ok[r_col]);
    assign w_cur_y    = r_base_y + BASE_W'(r_row);
    assign w_cur_x    = r_base_x + BASE_W'(r_col);

    // Any in-image tap still ahead of this one in scatter-add order
    // (shift amount one bit wider so the last kernel position shifts everything out)
    assign w_cols_after = r_col_ok &
                          (MAX_KERNEL'({MAX_KERNEL{1'b1}}) << ({1'b0, r_col} + (TAP_W+1)'(1)));
    assign w_rows_after = r_row_ok &
                          (MAX_KERNEL'({MAX_KERNEL{1'b1}}) << ({1'b0, r_row} + (TAP_W+1)'(1)));
    assign w_more       = (r_row_ok[r_row] && (|w_cols_after)) ||
                          ((|w_rows_after) && (|r_col_ok));
    assign w_rec_last   = (r_kind == KIND_SCATTER) ? !w_more : (w_last_row && w_last_col);

    assign o_sts.kernel_empty = (w_kh == '0) || (w_kw == '0);
    assign o_sts.tap_final    = w_last_row && w_last_col;
    assign o_sts.tap_emit     = (r_kind == KIND_GATHER) || !w_padded;
    assign o_sts.out_free     = !r_out_valid || o_out.ready;

    // Item capture and base coordinates
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in.kind;
            r_batch <= i_in.batch_index;
            r_oy    <= i_in.out_y;
            r_ox    <= i_in.out_x;
        end
        if (i_cmd.calc_base) begin
            r_base_y <= $signed(BASE_W'(w_prod_y)) - $signed(BASE_W'(i_cfg.pad_top));
            r_base_x <= $signed(BASE_W'(w_prod_x)) - $signed(BASE_W'(i_cfg.pad_left));
        end
        if (i_cmd.calc_mask) begin
            r_row_ok <= w_row_ok;
            r_col_ok <= w_col_ok;
        end
    end

    // Tap counters, row-major over the window
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_mask) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (i_cmd.step) begin
            r_slot <= r_slot + 1'b1;
            if (w_last_col) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_batch <= r_batch;
            r_out_y     <= w_padded ? '0 : w_cur_y[COORD_W-1:0];
            r_out_x     <= w_padded ? '0 : w_cur_x[COORD_W-1:0];
            r_out_slot  <= r_slot;
            r_out_zero  <= w_padded;
            r_out_last  <= w_rec_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.batch_out  = r_out_batch;
    assign o_out.in_y       = r_out_y;
    assign o_out.in_x       = r_out_x;
    assign o_out.slot_index = r_out_slot;
    assign o_out.zero_fill  = r_out_zero;
    assign o_out.last       = r_out_last;

endmodule

>>> rtl/im2col_tap_address_generator.sv
// Im2col tap address generator: one output position in, one record per kernel tap out.
// Each accepted position passes through acceptance, computation of the base coordinates
// (output coordinate times stride minus padding), building of the per-row and per-column
// padding masks, then, unless the kernel is empty, a walk over the kernel_height *
// kernel_width window at one tap per cycle while the output side does not stall. In
// scatter-add mode padded taps are still walked but produce no record. The next position
// is accepted once the walk is done, while the final record may still sit in the output
// register. Configuration goes through the APB port at byte address 4*i and may be
// changed only while the block is idle.
module im2col_tap_address_generator import itag_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    itag_in_if.sink           i_in,
    itag_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    itag_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    itag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    itag_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    assign i_in.ready = w_in_ready;

endmodule
